// ===== hdl/ymr_pkg.sv =====
package ymr_pkg;

  // block sizes
  localparam logic [10:0] SMALL_BLOCK_BYTES = 11'd128;
  localparam logic [10:0] LARGE_BLOCK_BYTES = 11'd1024;

  // protocol bytes
  localparam logic [7:0] B_SOH      = 8'h01;
  localparam logic [7:0] B_STX      = 8'h02;
  localparam logic [7:0] B_EOT      = 8'h04;
  localparam logic [7:0] B_ACK      = 8'h06;
  localparam logic [7:0] B_NAK      = 8'h15;
  localparam logic [7:0] B_CA       = 8'h18;
  localparam logic [7:0] B_C        = 8'h43;
  localparam logic [7:0] B_ABORT_UP = 8'h41;
  localparam logic [7:0] B_ABORT_LO = 8'h61;
  localparam logic [7:0] SEQ_INVERT = 8'hFF;

  // request kinds on the input side
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef enum logic [3:0] {
    V_DATA_OK     = 4'd0,
    V_HEADER_OK   = 4'd1,
    V_EMPTY_HDR   = 4'd2,
    V_WRONG_SEQ   = 4'd3,
    V_EOT         = 4'd4,
    V_SENDER_CAN  = 4'd5,
    V_ABORT       = 4'd6,
    V_ERR_RETRY   = 4'd7,
    V_TOO_MANY    = 4'd8
  } verdict_e;

  // one queued command: a payload byte, or up to two replies then a verdict
  typedef struct packed {
    logic       is_payload;
    logic [7:0] data;
    logic [9:0] index;
    logic       is_large;
    logic [1:0] nrep;
    logic [7:0] rep0;
    logic [7:0] rep1;
    verdict_e   verdict;
  } cmd_t;

endpackage

// ===== hdl/ymr_front.sv =====
module ymr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        retry_limit_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        rx_byte_i,
  output logic              push_o,
  output ymr_pkg::cmd_t     cmd_o,
  input  logic              full_i
);
  import ymr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_CANCEL = 3'b010,
    PH_BLOCK  = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        large_q, large_d;
  logic [10:0] pos_q, pos_d;
  logic [7:0]  seq_q, seq_d;
  logic        comp_ok_q, comp_ok_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic        await_hdr_q, await_hdr_d;
  logic [7:0]  err_cnt_q, err_cnt_d;
  logic        begun_q, begun_d;
  logic        hdr_ne_q, hdr_ne_d;

  logic        accept;
  logic [7:0]  err_inc;
  logic        too_many;
  logic [10:0] size_w;
  logic [10:0] pos_inc;
  logic        do_err;
  logic        do_clear;

  function automatic cmd_t reply_cmd(logic [1:0] nrep, logic [7:0] r0, logic [7:0] r1,
                                     verdict_e v, logic big);
    cmd_t c;
    c            = '0;
    c.is_payload = 1'b0;
    c.nrep       = nrep;
    c.rep0       = r0;
    c.rep1       = r1;
    c.verdict    = v;
    c.is_large   = big;
    return c;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign err_inc  = (begun_q && err_cnt_q != 8'hFF) ? err_cnt_q + 8'd1 : err_cnt_q;
  assign too_many = err_inc > retry_limit_i;
  assign size_w   = large_q ? LARGE_BLOCK_BYTES : SMALL_BLOCK_BYTES;
  assign pos_inc  = pos_q + 11'd1;

  // classify the request and update the session state
  always_comb begin
    phase_d     = phase_q;
    large_d     = large_q;
    pos_d       = pos_q;
    seq_d       = seq_q;
    comp_ok_d   = comp_ok_q;
    exp_seq_d   = exp_seq_q;
    await_hdr_d = await_hdr_q;
    err_cnt_d   = err_cnt_q;
    begun_d     = begun_q;
    hdr_ne_d    = hdr_ne_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    do_err      = 1'b0;
    do_clear    = 1'b0;

    if (accept) begin
      if (req_type_i == REQ_TIMEOUT) begin
        do_err = 1'b1;
      end else begin
        case (phase_q)
          PH_BLOCK: begin
            if (pos_q == 11'd0) begin
              seq_d = rx_byte_i;
            end else if (pos_q == 11'd1) begin
              comp_ok_d = (seq_q == (rx_byte_i ^ SEQ_INVERT));
            end else if (pos_q < size_w + 11'd2) begin
              if (pos_q == 11'd2) begin
                hdr_ne_d = (rx_byte_i != 8'd0);
              end
              push_o           = 1'b1;
              cmd_o            = '0;
              cmd_o.is_payload = 1'b1;
              cmd_o.data       = rx_byte_i;
              cmd_o.index      = pos_q[9:0] - 10'd2;
              cmd_o.is_large   = large_q;
            end
            pos_d = pos_inc;
            // end of block after the two crc bytes
            if (pos_inc >= size_w + 11'd4) begin
              if (!comp_ok_q) begin
                do_err = 1'b1;
              end else begin
                phase_d   = PH_IDLE;
                err_cnt_d = 8'd0;
                push_o    = 1'b1;
                if (seq_q != exp_seq_q) begin
                  cmd_o = reply_cmd(2'd1, B_NAK, 8'd0, V_WRONG_SEQ, large_q);
                end else if (await_hdr_q) begin
                  if (!hdr_ne_q) begin
                    cmd_o    = reply_cmd(2'd1, B_ACK, 8'd0, V_EMPTY_HDR, large_q);
                    do_clear = 1'b1;
                  end else begin
                    cmd_o       = reply_cmd(2'd2, B_ACK, B_C, V_HEADER_OK, large_q);
                    await_hdr_d = 1'b0;
                    exp_seq_d   = exp_seq_q + 8'd1;
                    begun_d     = 1'b1;
                  end
                end else begin
                  cmd_o     = reply_cmd(2'd1, B_ACK, 8'd0, V_DATA_OK, large_q);
                  exp_seq_d = exp_seq_q + 8'd1;
                  begun_d   = 1'b1;
                end
              end
            end
          end
          PH_CANCEL: begin
            if (rx_byte_i == B_CA) begin
              push_o   = 1'b1;
              cmd_o    = reply_cmd(2'd1, B_ACK, 8'd0, V_SENDER_CAN, large_q);
              do_clear = 1'b1;
            end else begin
              do_err = 1'b1;
            end
          end
          default: begin
            if (rx_byte_i == B_SOH || rx_byte_i == B_STX) begin
              large_d   = (rx_byte_i == B_STX);
              pos_d     = 11'd0;
              comp_ok_d = 1'b0;
              hdr_ne_d  = 1'b0;
              phase_d   = PH_BLOCK;
            end else if (rx_byte_i == B_EOT) begin
              err_cnt_d   = 8'd0;
              push_o      = 1'b1;
              cmd_o       = reply_cmd(2'd1, B_ACK, 8'd0, V_EOT, large_q);
              exp_seq_d   = 8'd0;
              await_hdr_d = 1'b1;
              phase_d     = PH_IDLE;
            end else if (rx_byte_i == B_CA) begin
              phase_d = PH_CANCEL;
            end else if (rx_byte_i == B_ABORT_UP || rx_byte_i == B_ABORT_LO) begin
              push_o   = 1'b1;
              cmd_o    = reply_cmd(2'd2, B_CA, B_CA, V_ABORT, large_q);
              do_clear = 1'b1;
            end else begin
              do_err = 1'b1;
            end
          end
        endcase
      end

      // error path: count and either retry or cancel the session
      if (do_err) begin
        phase_d   = PH_IDLE;
        err_cnt_d = err_inc;
        push_o    = 1'b1;
        if (too_many) begin
          cmd_o    = reply_cmd(2'd2, B_CA, B_CA, V_TOO_MANY, large_q);
          do_clear = 1'b1;
        end else begin
          cmd_o = reply_cmd(2'd1, B_C, 8'd0, V_ERR_RETRY, large_q);
        end
      end

      // session end
      if (do_clear) begin
        phase_d     = PH_IDLE;
        large_d     = 1'b0;
        pos_d       = 11'd0;
        seq_d       = 8'd0;
        comp_ok_d   = 1'b0;
        exp_seq_d   = 8'd0;
        await_hdr_d = 1'b1;
        err_cnt_d   = 8'd0;
        begun_d     = 1'b0;
        hdr_ne_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      large_q     <= 1'b0;
      pos_q       <= 11'd0;
      seq_q       <= 8'd0;
      comp_ok_q   <= 1'b0;
      exp_seq_q   <= 8'd0;
      await_hdr_q <= 1'b1;
      err_cnt_q   <= 8'd0;
      begun_q     <= 1'b0;
      hdr_ne_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      large_q     <= large_d;
      pos_q       <= pos_d;
      seq_q       <= seq_d;
      comp_ok_q   <= comp_ok_d;
      exp_seq_q   <= exp_seq_d;
      await_hdr_q <= await_hdr_d;
      err_cnt_q   <= err_cnt_d;
      begun_q     <= begun_d;
      hdr_ne_q    <= hdr_ne_d;
    end
  end

  // byte position never runs past the end of a large block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LARGE_BLOCK_BYTES + 11'd4)
    else $error("byte position out of range");

  // a payload request only comes out of block phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.is_payload) |-> (phase_q == PH_BLOCK && pos_q >= 11'd2))
    else $error("payload outside block body");

endmodule

// ===== hdl/ymr_fifo.sv =====
module ymr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ymr_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ymr_pkg::cmd_t rdata_o
);
  import ymr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // the writer never pushes into a full queue, the reader never pops an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("queue push lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ===== hdl/ymr_back.sv =====
module ymr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ymr_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_byte_o,
  output logic [9:0]    payload_index_o,
  output logic          large_block_o,
  output logic [3:0]    verdict_o,
  output logic          last_o
);
  import ymr_pkg::*;

  logic [1:0] step_q, step_d;
  logic       xfer;

  assign out_valid_o = head_valid_i;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && last_o;

  // expand the head command into its result items
  always_comb begin
    out_kind_o      = KIND_VERDICT;
    out_byte_o      = 8'd0;
    payload_index_o = 10'd0;
    large_block_o   = 1'b0;
    verdict_o       = 4'd0;
    last_o          = 1'b0;
    if (head_i.is_payload) begin
      out_kind_o      = KIND_PAYLOAD;
      out_byte_o      = head_i.data;
      payload_index_o = head_i.index;
      large_block_o   = head_i.is_large;
      last_o          = 1'b1;
    end else if (step_q < head_i.nrep) begin
      out_kind_o = KIND_REPLY;
      out_byte_o = step_q[0] ? head_i.rep1 : head_i.rep0;
    end else begin
      out_kind_o    = KIND_VERDICT;
      large_block_o = head_i.is_large;
      verdict_o     = head_i.verdict;
      last_o        = 1'b1;
    end
  end

  always_comb begin
    step_d = step_q;
    if (xfer) begin
      step_d = last_o ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
    end else begin
      step_q <= step_d;
    end
  end

  // the step counter stays within the replies of the head command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && !head_i.is_payload) |-> (step_q <= head_i.nrep))
    else $error("reply step past verdict");

  // a popped command restarts the step counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == 2'd0))
    else $error("step not cleared after pop");

endmodule

// ===== hdl/ymodem_packet_receiver.sv =====
// YMODEM receive-side packet engine.
//
// Input stream: one request per item. tuser[0] = 1 marks a timeout of the wait
// for a byte, otherwise tdata[7:0] is a byte from the sender. Output stream:
// tuser[1:0] is the result kind (payload, reply byte, block verdict), tdata
// carries the byte, payload offset, block size flag and verdict, and tlast marks
// the last result caused by one request. Requests that cause no result (block
// start, first CA, sequence, complement and first crc bytes) produce nothing.
// The front end classifies each request and updates the session state in the
// cycle it is taken; its commands go through a small queue to the back end,
// which expands each command into one to three results, one per cycle unless
// the output stalls. Each command is registered in the queue on its way out.
// One request per cycle while the queue has room; a block body streams at one
// byte per cycle. A block end or control byte with two or three results holds
// the back end while it sends them, and the queue absorbs it while the front
// keeps accepting. When the output is stalled the queue fills and s_axis_tready_o
// drops. Reset empties the queue, returns the session to waiting for a block
// start and sets the error limit (APB register at address 0) to 5.
module ymodem_packet_receiver #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // rx_byte
  input  logic [0:0]  s_axis_tuser_i,  // req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // out_byte, payload_index, large_block, verdict
  output logic [1:0]  m_axis_tuser_o,  // out_kind
  output logic        m_axis_tlast_o
);
  import ymr_pkg::*;

  logic [7:0] retry_limit_q;
  logic       cfg_wr;

  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_head;

  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [9:0] payload_index;
  logic       large_block;
  logic [3:0] verdict;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, retry_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= 8'd5;
    end else if (cfg_wr) begin
      retry_limit_q <= pwdata[7:0];
    end
  end

  ymr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .retry_limit_i (retry_limit_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .req_type_i    (s_axis_tuser_i[0]),
    .rx_byte_i     (s_axis_tdata_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (q_full)
  );

  ymr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_head)
  );

  ymr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_valid),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_kind_o      (out_kind),
    .out_byte_o      (out_byte),
    .payload_index_o (payload_index),
    .large_block_o   (large_block),
    .verdict_o       (verdict),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_kind;
  assign m_axis_tdata_o = {1'b0, verdict, large_block, payload_index, out_byte};

endmodule

// ===== tb/ymr_result_checker.sv =====
module ymr_result_checker #(
  parameter logic [2:0] RETRY_LIMIT_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port, watched only
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // request stream
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [7:0]  req_data_i,   // rx_byte
  input  logic [0:0]  req_user_i,   // req_type
  // result stream
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [23:0] res_data_i,   // out_byte, payload_index, large_block, verdict
  input  logic [1:0]  res_user_i,   // out_kind
  input  logic        res_last_i,
  // status for the stimulus side
  output int          mismatches_o,
  output int          pending_o,
  output int          requests_o,
  output int          results_o,
  output logic [8:0]  verdicts_seen_o,
  output logic [7:0]  seq_hint_o,
  output logic        header_hint_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ymr_pkg::*;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_CANCEL,
    RX_BODY
  } rx_phase_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [9:0] offset;
    logic       is_large;
    verdict_e   verdict;
    logic       last;
  } rx_result_t;

  // session state of the receive engine
  rx_phase_e   rx_phase;
  logic        blk_large;
  logic [10:0] body_pos;
  logic [7:0]  seq_got;
  logic        cpl_good;
  logic [7:0]  seq_want;
  logic        hdr_wait;
  logic [7:0]  err_cnt;
  logic        begun;
  logic        hdr_nonempty;
  logic [7:0]  err_limit;

  rx_result_t  step_q[$];
  rx_result_t  expected_q[$];
  rx_result_t  want;

  task automatic report(input string msg);
    mismatches_o++;
    $display("[%0t] result %0d: %s", $time, results_o, msg);
  endtask

  task automatic check_field(input string name, input logic [9:0] got,
                             input logic [9:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("%s got %0h expected %0h", name, got, exp_val));
    end
  endtask

  task automatic clear_session();
    rx_phase     = RX_IDLE;
    blk_large    = 1'b0;
    body_pos     = '0;
    seq_got      = '0;
    cpl_good     = 1'b0;
    seq_want     = '0;
    hdr_wait     = 1'b1;
    err_cnt      = '0;
    begun        = 1'b0;
    hdr_nonempty = 1'b0;
  endtask

  task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                      input logic [9:0] offset, input logic is_large, input verdict_e v);
    rx_result_t r;
    r.kind     = kind;
    r.data     = data;
    r.offset   = offset;
    r.is_large = is_large;
    r.verdict  = v;
    r.last     = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic reply_byte(input logic [7:0] b);
    emit(KIND_REPLY, b, '0, 1'b0, V_DATA_OK);
  endtask

  task automatic give_verdict(input verdict_e v);
    emit(KIND_VERDICT, 8'h00, '0, blk_large, v);
  endtask

  // timeout, bad start byte, broken cancel or bad complement
  task automatic take_error();
    rx_phase = RX_IDLE;
    if (begun && err_cnt != 8'hFF) err_cnt = err_cnt + 8'd1;
    if (err_cnt > err_limit) begin
      reply_byte(B_CA);
      reply_byte(B_CA);
      give_verdict(V_TOO_MANY);
      clear_session();
    end else begin
      reply_byte(B_C);
      give_verdict(V_ERR_RETRY);
    end
  endtask

  // last crc byte taken: judge the block
  task automatic close_block();
    if (!cpl_good) begin
      take_error();
    end else begin
      rx_phase = RX_IDLE;
      err_cnt  = '0;
      if (seq_got != seq_want) begin
        reply_byte(B_NAK);
        give_verdict(V_WRONG_SEQ);
      end else if (hdr_wait && !hdr_nonempty) begin
        reply_byte(B_ACK);
        give_verdict(V_EMPTY_HDR);
        clear_session();
      end else begin
        if (hdr_wait) begin
          reply_byte(B_ACK);
          reply_byte(B_C);
          give_verdict(V_HEADER_OK);
          hdr_wait = 1'b0;
        end else begin
          reply_byte(B_ACK);
          give_verdict(V_DATA_OK);
        end
        seq_want = seq_want + 8'd1;
        begun    = 1'b1;
      end
    end
  endtask

  // expected results of one accepted request
  task automatic predict_request(input logic req, input logic [7:0] b);
    logic [10:0] size;
    logic [10:0] off;
    rx_result_t  r;
    step_q.delete();
    size = blk_large ? LARGE_BLOCK_BYTES : SMALL_BLOCK_BYTES;
    if (req == REQ_TIMEOUT) begin
      take_error();
    end else begin
      case (rx_phase)
        RX_BODY: begin
          if (body_pos == 11'd0) begin
            seq_got = b;
          end else if (body_pos == 11'd1) begin
            cpl_good = (seq_got == (b ^ SEQ_INVERT));
          end else if (body_pos < size + 11'd2) begin
            if (body_pos == 11'd2) hdr_nonempty = (b != 8'h00);
            off = body_pos - 11'd2;
            emit(KIND_PAYLOAD, b, off[9:0], blk_large, V_DATA_OK);
          end
          body_pos = body_pos + 11'd1;
          if (body_pos >= size + 11'd4) close_block();
        end
        RX_CANCEL: begin
          if (b == B_CA) begin
            reply_byte(B_ACK);
            give_verdict(V_SENDER_CAN);
            clear_session();
          end else begin
            take_error();
          end
        end
        default: begin
          if (b == B_SOH || b == B_STX) begin
            blk_large    = (b == B_STX);
            body_pos     = '0;
            cpl_good     = 1'b0;
            hdr_nonempty = 1'b0;
            rx_phase     = RX_BODY;
          end else if (b == B_EOT) begin
            err_cnt = '0;
            reply_byte(B_ACK);
            give_verdict(V_EOT);
            seq_want = '0;
            hdr_wait = 1'b1;
            rx_phase = RX_IDLE;
          end else if (b == B_CA) begin
            rx_phase = RX_CANCEL;
          end else if (b == B_ABORT_UP || b == B_ABORT_LO) begin
            reply_byte(B_CA);
            reply_byte(B_CA);
            give_verdict(V_ABORT);
            clear_session();
          end else begin
            take_error();
          end
        end
      endcase
    end
    // tlast goes on the final result of this request
    foreach (step_q[i]) begin
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_limit = 8'd5;
      clear_session();
      expected_q.delete();
      mismatches_o    = 0;
      requests_o      = 0;
      results_o       = 0;
      verdicts_seen_o = '0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RETRY_LIMIT_ADDR) begin
        err_limit = pwdata_i[7:0];
      end
      // compare an accepted result with the oldest expectation
      if (res_valid_i && res_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("out_kind", 10'(res_user_i), 10'(want.kind));
          check_field("out_byte", 10'(res_data_i[7:0]), 10'(want.data));
          check_field("payload_index", res_data_i[17:8], want.offset);
          check_field("large_block", 10'(res_data_i[18]), 10'(want.is_large));
          check_field("verdict", 10'(res_data_i[22:19]), 10'(want.verdict));
          check_field("tdata pad", 10'(res_data_i[23]), 10'd0);
          check_field("tlast", 10'(res_last_i), 10'(want.last));
          if (want.kind == KIND_VERDICT) verdicts_seen_o[want.verdict] = 1'b1;
        end
      end
      // predict an accepted request
      if (req_valid_i && req_ready_i) begin
        requests_o++;
        predict_request(req_user_i[0], req_data_i);
      end
    end
    pending_o     = expected_q.size();
    seq_hint_o    = seq_want;
    header_hint_o = hdr_wait;
  end

endmodule

// ===== tb/tb_ymodem_packet_receiver.sv =====
module tb_ymodem_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import ymr_pkg::*;

  localparam logic [2:0] RETRY_LIMIT_ADDR = 3'd0;
  localparam int LIMIT_CYCLES = 60_000;
  localparam int ITEM_TARGET  = 380;
  localparam int LIMIT_EVERY  = 12;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // rx_byte
  logic [0:0]  s_axis_tuser_i;   // req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // out_byte, payload_index, large_block, verdict
  logic [1:0]  m_axis_tuser_o;   // out_kind
  logic        m_axis_tlast_o;

  int          mismatches;
  int          pending;
  int          requests;
  int          results;
  logic [8:0]  verdicts_seen;
  logic [7:0]  seq_hint;
  logic        header_hint;

  int          cycles = 0;
  int          hold_count = 0;
  int          holds_done = 0;
  int          burst_left = 1;
  int          limit_writes = 0;

  ymodem_packet_receiver uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  ymr_result_checker #(
    .RETRY_LIMIT_ADDR(RETRY_LIMIT_ADDR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .req_valid_i    (s_axis_tvalid_i),
    .req_ready_i    (s_axis_tready_o),
    .req_data_i     (s_axis_tdata_i),
    .req_user_i     (s_axis_tuser_i),
    .res_valid_i    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .res_data_i     (m_axis_tdata_o),
    .res_user_i     (m_axis_tuser_o),
    .res_last_i     (m_axis_tlast_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .requests_o     (requests),
    .results_o      (results),
    .verdicts_seen_o(verdicts_seen),
    .seq_hint_o     (seq_hint),
    .header_hint_o  (header_hint)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_ymodem_packet_receiver failed");
      $finish;
    end
  end

  // result side stalls: a few patterns, plus a long hold-off on request
  initial begin
    int mode;
    int span;
    int tick;
    m_axis_tready_i = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (holds_done != hold_count) begin
          m_axis_tready_i = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          holds_done = hold_count;
        end
        case (mode)
          0: m_axis_tready_i = 1'b1;
          1: m_axis_tready_i = 1'($urandom_range(0, 1));
          2: m_axis_tready_i = (tick % 5 == 0) || (tick % 5 == 3);
          default: m_axis_tready_i = ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 9);
    if (p < 3) return 0;
    if (p < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic int burst_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 12);
    return $urandom_range(50, 200);
  endfunction

  // offer one request and wait for it to be taken; bursts and gaps between them
  task automatic send(input logic req, input logic [7:0] b);
    int gap;
    s_axis_tuser_i  = req;
    s_axis_tdata_i  = b;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      gap = gap_len();
      if (gap > 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = burst_len();
    end
  endtask

  // stop sending until every expected result is out
  task automatic settle();
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_retry_limit(input logic [7:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = RETRY_LIMIT_ADDR;
    pwdata  = {24'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    limit_writes++;
  endtask

  // start byte, seq, complement, payload, two crc bytes; cut >= 0 puts a
  // timeout in place of that body byte
  task automatic send_block(input logic is_large, input logic [7:0] seq, input logic cpl_ok,
                            input logic [7:0] first, input fill_e fill, input int cut);
    int         body_len;
    logic [7:0] b;
    body_len = int'(is_large ? LARGE_BLOCK_BYTES : SMALL_BLOCK_BYTES) + 4;
    send(REQ_BYTE, is_large ? B_STX : B_SOH);
    for (int i = 0; i < body_len; i++) begin
      if (i == cut) begin
        send(REQ_TIMEOUT, 8'($urandom));
        return;
      end
      if (i == 0) b = seq;
      else if (i == 1) b = cpl_ok ? ~seq : (~seq ^ 8'($urandom_range(1, 255)));
      else if (i == 2) b = first;
      else if (fill == FILL_ZERO) b = 8'h00;
      else if (fill == FILL_ONES) b = 8'hFF;
      else b = 8'($urandom);
      send(REQ_BYTE, b);
    end
  endtask

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_limit();
    int p;
    p = $urandom_range(0, 5);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd1;
    if (p == 2) return 8'd255;
    if (p == 3) return 8'd5;
    return 8'($urandom_range(2, 254));
  endfunction

  // one short random protocol element
  task automatic random_element();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // a block of either size broken off near its start
      send_block(($urandom_range(0, 3) == 0), 8'($urandom), ($urandom_range(0, 3) != 0),
                 8'($urandom), FILL_RANDOM, $urandom_range(0, 5));
    end else if (pick < 32) begin
      send(REQ_BYTE, B_EOT);
    end else if (pick < 44) begin
      send(REQ_BYTE, B_CA);
      send(REQ_BYTE, B_CA);
    end else if (pick < 52) begin
      send(REQ_BYTE, B_CA);
      send(REQ_BYTE, 8'($urandom));
    end else if (pick < 60) begin
      send(REQ_BYTE, $urandom_range(0, 1) ? B_ABORT_UP : B_ABORT_LO);
    end else if (pick < 78) begin
      send(REQ_TIMEOUT, 8'($urandom));
    end else begin
      // line noise; a stray start or cancel byte is broken off by a timeout
      b = 8'($urandom);
      send(REQ_BYTE, b);
      if (b == B_SOH || b == B_STX || b == B_CA) send(REQ_TIMEOUT, 8'($urandom));
    end
  endtask

  initial begin
    int n;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_BYTE;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // stray bytes and every control sequence before any session
    send(REQ_TIMEOUT, 8'hFF);
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, B_CA);
    send(REQ_BYTE, 8'h5A);
    send(REQ_BYTE, B_CA);
    send(REQ_BYTE, B_CA);
    send(REQ_BYTE, B_ABORT_UP);
    send(REQ_BYTE, B_ABORT_LO);
    send(REQ_BYTE, B_EOT);
    // a large block broken off a few payload bytes in
    send_block(1'b1, 8'h00, 1'b1, nonzero_byte(), FILL_RANDOM, 6);

    // header block while the result side holds off for a long stretch
    hold_count++;
    send_block(1'b0, 8'h00, 1'b1, nonzero_byte(), FILL_RANDOM, -1);

    // tight limit: one counted error, then a second block of random kind
    settle();
    write_retry_limit(8'd1);
    send_block(1'b0, seq_hint, 1'b1, 8'($urandom), FILL_RANDOM, 3);
    case ($urandom_range(0, 3))
      0: send_block(1'b0, seq_hint, 1'b1, 8'($urandom), FILL_RANDOM, -1);
      1: send_block(1'b0, seq_hint + 8'd5, 1'b1, 8'($urandom), FILL_ZERO, -1);
      2: send_block(1'b0, seq_hint, 1'b0, 8'($urandom), FILL_ONES, -1);
      default: begin
        send(REQ_BYTE, B_EOT);
        send_block(1'b0, 8'h00, 1'b1, 8'h00, FILL_RANDOM, -1);
      end
    endcase
    send(REQ_TIMEOUT, 8'h00);
    send(REQ_TIMEOUT, 8'h00);

    // short random elements under changing limits
    n = 0;
    while (requests < ITEM_TARGET) begin
      if (n % LIMIT_EVERY == 0) begin
        settle();
        write_retry_limit(pick_limit());
      end
      random_element();
      n++;
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("sent %0d requests, checked %0d results, %0d limit writes, one long hold-off",
             requests, results, limit_writes);
    $display("verdict kinds seen, 8 down to 0: %b", verdicts_seen);
    if (mismatches == 0) begin
      $display("tb_ymodem_packet_receiver passed");
    end else begin
      $display("tb_ymodem_packet_receiver failed");
    end
    $finish;
  end

endmodule
